/* hdl/obpa_pkg.sv */
// obpa_pkg: shared types, constants and helpers for the block pool allocator
// no dependencies
`timescale 1ns / 1ps

package obpa_pkg;

  localparam int NUM_BLOCKS  = 16;
  localparam int BLOCK_BYTES = 32;

  localparam int TASK_W  = 8;
  localparam int OFF_W   = 9;
  localparam int STAT_W  = 2;
  localparam int FCNT_W  = 5;
  localparam int IDX_W   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W   = $clog2(NUM_BLOCKS + 1);
  localparam int PROD_W  = IDX_W + OFF_W;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 2'd0,
    ST_FULL        = 2'd1,
    ST_NOT_FOUND   = 2'd2,
    ST_WRONG_OWNER = 2'd3
  } status_t;

  typedef struct packed {
    logic              is_alloc;
    logic [TASK_W-1:0] task_id;
    logic              hit;
    logic [IDX_W-1:0]  idx;
    logic [OFF_W-1:0]  offset;
  } item_t;

  // byte offset of a block start, masked to the offset width
  function automatic logic [OFF_W-1:0] block_base(input logic [IDX_W-1:0] idx);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(idx) * PROD_W'(BLOCK_BYTES);
    return prod[OFF_W-1:0];
  endfunction

  // free block count from used count, masked to the output width
  function automatic logic [FCNT_W-1:0] free_of(input logic [CNT_W-1:0] used);
    logic [CNT_W-1:0]        diff;
    logic [CNT_W+FCNT_W-1:0] wide;
    diff = CNT_W'(NUM_BLOCKS) - used;
    wide = (CNT_W + FCNT_W)'(diff);
    return wide[FCNT_W-1:0];
  endfunction

endpackage

/* hdl/obpa_front.sv */
// obpa_front: accepts requests and classifies the free offset into a block index
// depends on obpa_pkg
`timescale 1ns / 1ps

module obpa_front (
  input  logic                      push,
  output logic                      full,
  input  logic                      req_type,
  input  logic [obpa_pkg::TASK_W-1:0] task_id,
  input  logic [obpa_pkg::OFF_W-1:0]  free_offset,
  input  logic                      q_full,
  output logic                      q_wr,
  output obpa_pkg::item_t           q_item
);

  logic [obpa_pkg::NUM_BLOCKS-1:0] match;
  logic [obpa_pkg::IDX_W-1:0]      idx;

  // offset names block k only when it equals k * block size exactly
  always_comb begin
    idx = '0;
    for (int k = 0; k < obpa_pkg::NUM_BLOCKS; k++) begin
      match[k] = (obpa_pkg::PROD_W'(free_offset) ==
                  obpa_pkg::PROD_W'(k * obpa_pkg::BLOCK_BYTES));
      if (match[k]) begin
        idx = idx | obpa_pkg::IDX_W'(k);
      end
    end
  end

  always_comb begin
    q_item.is_alloc = (req_type == obpa_pkg::REQ_ALLOC);
    q_item.task_id  = task_id;
    q_item.hit      = |match;
    q_item.idx      = idx;
    q_item.offset   = free_offset;
  end

  assign full = q_full;
  assign q_wr = push && !q_full;

endmodule

/* hdl/obpa_queue.sv */
// obpa_queue: two-entry queue of classified requests between front and back
// depends on obpa_pkg
`timescale 1ns / 1ps

module obpa_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  obpa_pkg::item_t wr_item,
  output logic            q_full,
  input  logic            rd,
  output logic            rd_valid,
  output obpa_pkg::item_t rd_item
);

  obpa_pkg::item_t slots [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign q_full   = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr, rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/obpa_back.sv */
// obpa_back: executes requests on the in-use map and owner table, holds the result
// depends on obpa_pkg
`timescale 1ns / 1ps

module obpa_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rd_valid,
  input  obpa_pkg::item_t             rd_item,
  output logic                        rd,
  output logic                        empty,
  input  logic                        pop,
  output logic [obpa_pkg::STAT_W-1:0] status,
  output logic [obpa_pkg::OFF_W-1:0]  block_offset,
  output logic [obpa_pkg::FCNT_W-1:0] free_count
);

  logic [obpa_pkg::NUM_BLOCKS-1:0] in_use;
  logic [obpa_pkg::NUM_BLOCKS-1:0] in_use_next;
  logic [obpa_pkg::TASK_W-1:0]     owner [obpa_pkg::NUM_BLOCKS];
  logic [obpa_pkg::CNT_W-1:0]      used_count;
  logic [obpa_pkg::CNT_W-1:0]      used_count_next;
  logic                            out_valid;

  logic                       take;
  logic                       found;
  logic [obpa_pkg::IDX_W-1:0] fidx;
  logic                       owner_wr;
  obpa_pkg::status_t          st;
  logic [obpa_pkg::OFF_W-1:0] res_off;

  assign empty = !out_valid;
  assign take  = rd_valid && (!out_valid || pop);
  assign rd    = take;

  // lowest free block
  always_comb begin
    fidx  = '0;
    found = 1'b0;
    for (int i = obpa_pkg::NUM_BLOCKS - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        fidx  = obpa_pkg::IDX_W'(i);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    in_use_next     = in_use;
    used_count_next = used_count;
    owner_wr        = 1'b0;
    st              = obpa_pkg::ST_NOT_FOUND;
    res_off         = '0;
    if (rd_item.is_alloc) begin
      if (found) begin
        in_use_next[fidx] = 1'b1;
        used_count_next   = used_count + obpa_pkg::CNT_W'(1);
        owner_wr          = 1'b1;
        st                = obpa_pkg::ST_OK;
        res_off           = obpa_pkg::block_base(fidx);
      end else begin
        st = obpa_pkg::ST_FULL;
      end
    end else if (rd_item.hit && in_use[rd_item.idx]) begin
      if (owner[rd_item.idx] != rd_item.task_id) begin
        st = obpa_pkg::ST_WRONG_OWNER;
      end else begin
        in_use_next[rd_item.idx] = 1'b0;
        if (used_count != '0) begin
          used_count_next = used_count - obpa_pkg::CNT_W'(1);
        end
        st      = obpa_pkg::ST_OK;
        res_off = rd_item.offset;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && owner_wr) begin
      owner[fidx] <= rd_item.task_id;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      status       <= st;
      block_offset <= res_off;
      free_count   <= obpa_pkg::free_of(used_count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use     <= '0;
      used_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (take) begin
        in_use     <= in_use_next;
        used_count <= used_count_next;
        out_valid  <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hdl/owned_block_pool_allocator_top.sv */
// owned_block_pool_allocator_top: pool of equal blocks tagged with the owning task
// depends on obpa_pkg, obpa_front, obpa_queue, obpa_back
`timescale 1ns / 1ps

// requests enter as a queue write: a beat is taken at a clock edge where push
// is high and full is low; req_type selects allocate or free, task_id names
// the owner, free_offset is the byte offset to release
// results leave as a queue read: while empty is low the oldest result sits on
// status, block_offset and free_count, and a beat completes where pop is high
// the front classifies the offset against block starts and writes a two-entry
// queue; the back takes one request a cycle from it while the result register
// is empty or popped, and updates the in-use map, owner table and used count
// in that same cycle into the result register; a request passes the queue
// slot and then the result register; sustained rate is one request per cycle
// while pop is held high, set by the update of the in-use map in the back stage
// when pop is held low the result register stays, the back stops, the queue
// fills and full rises after two more requests
// rst is synchronous: all blocks free, queue and result register empty; the
// owner table is not cleared since an entry is read only while its block is used

module owned_block_pool_allocator_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        req_type,
  input  logic [obpa_pkg::TASK_W-1:0] task_id,
  input  logic [obpa_pkg::OFF_W-1:0]  free_offset,
  output logic                        empty,
  input  logic                        pop,
  output logic [obpa_pkg::STAT_W-1:0] status,
  output logic [obpa_pkg::OFF_W-1:0]  block_offset,
  output logic [obpa_pkg::FCNT_W-1:0] free_count
);

  logic            q_full;
  logic            q_wr;
  obpa_pkg::item_t q_item;
  logic            rd;
  logic            rd_valid;
  obpa_pkg::item_t rd_item;

  obpa_front u_front (
    .push        (push),
    .full        (full),
    .req_type    (req_type),
    .task_id     (task_id),
    .free_offset (free_offset),
    .q_full      (q_full),
    .q_wr        (q_wr),
    .q_item      (q_item)
  );

  obpa_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_wr),
    .wr_item  (q_item),
    .q_full   (q_full),
    .rd       (rd),
    .rd_valid (rd_valid),
    .rd_item  (rd_item)
  );

  obpa_back u_back (
    .clk          (clk),
    .rst          (rst),
    .rd_valid     (rd_valid),
    .rd_item      (rd_item),
    .rd           (rd),
    .empty        (empty),
    .pop          (pop),
    .status       (status),
    .block_offset (block_offset),
    .free_count   (free_count)
  );

endmodule
